FILE: hdl/frame_rotator_90_180_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the frame rotator
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef FRAME_ROTATOR_90_180_MACROS_SVH
`define FRAME_ROTATOR_90_180_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define FR90_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define FR90_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define FR90_ASSERT(label, clk, rst, prop, msg)
`define FR90_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

FILE: hdl/fr90_pkg.sv
// ---------------------------------------------------------------------------
// fr90_pkg
// Shared constants, types and helpers of the frame rotator.
// ---------------------------------------------------------------------------
`default_nettype none

package fr90_pkg;

  localparam int MAX_DIM     = 256;
  localparam int FRAME_DEPTH = 65536;   // MAX_DIM * MAX_DIM

  localparam int PIX_W     = 24;
  localparam int CFG_DIM_W = 9;
  localparam int ROT_W     = 2;
  localparam int DIM_W     = $clog2(MAX_DIM) + 1;
  localparam int CNT_W     = $clog2(MAX_DIM);
  localparam int ADDR_W    = $clog2(FRAME_DEPTH);
  localparam int SIZE_W    = $clog2(FRAME_DEPTH) + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH) + 1;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_ROTATION = 2'd2;

  localparam logic [ROT_W-1:0] ROT_QUARTER = 2'd0;
  localparam logic [ROT_W-1:0] ROT_HALF    = 2'd1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] width;
    logic [CFG_DIM_W-1:0] height;
    logic [ROT_W-1:0]     rotation;
  } fr90_cfg_t;

  // one classified operation between front and back
  typedef struct packed {
    logic              fetch;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
    logic              row_end;
    logic              frame_end;
  } fr90_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fr90_qstat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_end;
  } fr90_pix_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (int'(v) > MAX_DIM) return DIM_W'(MAX_DIM);
    return DIM_W'(v);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/frame_rotator_90_180.sv
// ---------------------------------------------------------------------------
// frame_rotator_90_180
// Frame store with quarter-turn, half-turn and pass-through readout.
// ---------------------------------------------------------------------------
// Items arrive on the slave stream: tuser 0 loads tdata into the frame store
// at the next source raster position, tuser 1 fetches the next pixel of the
// rotated image, which leaves on the master stream with tuser marking the end
// of an output row and tlast the end of the frame. The block sustains one
// item per clock in either mode while the queue and, for fetches, the output
// buffer have room; the rate is set by the single port of the frame store,
// which takes one write or one read each cycle. The user must write image
// width, height and rotation over the register port only while no item is
// in flight; the block does not check this. A size change that leaves the
// load or readout position beyond the new frame restarts it at zero. The
// frame store has no reset: fetch only pixels that were loaded.
// ---------------------------------------------------------------------------
`default_nettype none
`include "frame_rotator_90_180_macros.svh"

module frame_rotator_90_180
  import fr90_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // item input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [23:0] pixel_in
  input  wire logic        s_axis_tuser,   // [0] mode
  // result output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,   // [23:0] pixel_out
  output logic             m_axis_tuser,   // [0] row_end
  output logic             m_axis_tlast    // frame_end
);

  fr90_cfg_t   cfg;
  logic        cfg_wr;
  logic [1:0]  reg_idx;
  logic        push;
  fr90_op_t    push_op;
  fr90_op_t    head;
  fr90_qstat_t q_stat;
  logic        pop;
  fr90_pix_t   out_pix;

  // Register port: no wait states, write on the access phase.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width    <= CFG_DIM_W'(256);
      cfg.height   <= CFG_DIM_W'(256);
      cfg.rotation <= ROT_QUARTER;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIDTH:    cfg.width    <= pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT:   cfg.height   <= pwdata[CFG_DIM_W-1:0];
        REG_ROTATION: cfg.rotation <= pwdata[ROT_W-1:0];
        default:      ;   // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:    prdata = 32'(cfg.width);
      REG_HEIGHT:   prdata = 32'(cfg.height);
      REG_ROTATION: prdata = 32'(cfg.rotation);
      default:      prdata = '0;
    endcase
  end

  // Front: classify items and compute store addresses.
  fr90_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_mode  (s_axis_tuser),
    .in_pixel (s_axis_tdata),
    .q_stat   (q_stat),
    .push     (push),
    .push_op  (push_op)
  );

  // Queue: decouple acceptance from store access and output stalls.
  fr90_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  // Back: write or read the frame store, hold fetched pixels for the sink.
  fr90_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pix   (out_pix)
  );

  assign m_axis_tdata = out_pix.pixel;
  assign m_axis_tuser = out_pix.row_end;
  assign m_axis_tlast = out_pix.frame_end;

  `FR90_ASSERT(a_frame_end_row_end, clk, rst, (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser, "frame end without row end")

endmodule

`default_nettype wire

FILE: hdl/fr90_ram.sv
// ---------------------------------------------------------------------------
// fr90_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fr90_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fr90_fifo.sv
// ---------------------------------------------------------------------------
// fr90_fifo
// Short operation queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none
`include "frame_rotator_90_180_macros.svh"

module fr90_fifo
  import fr90_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire fr90_op_t    push_op,
  input  wire logic        pop,
  output fr90_op_t         head,
  output fr90_qstat_t      stat
);

  fr90_op_t            slots [FIFO_DEPTH];
  logic [FPTR_W-1:0]   wr_ptr;
  logic [FPTR_W-1:0]   rd_ptr;
  logic [FCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign stat.full  = (count == FCNT_W'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + FPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + FPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + FCNT_W'(1);
        2'b01:   count <= count - FCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `FR90_ASSERT_NEVER(a_no_push_full, clk, rst, push && stat.full, "push into full queue")
  `FR90_ASSERT(a_count_range, clk, rst, count <= FCNT_W'(FIFO_DEPTH), "queue count overflow")

endmodule

`default_nettype wire

FILE: hdl/fr90_front.sv
// ---------------------------------------------------------------------------
// fr90_front
// Accepts items, tracks load and readout positions, computes store addresses.
// ---------------------------------------------------------------------------
`default_nettype none

module fr90_front
  import fr90_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fr90_cfg_t        cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_mode,
  input  wire logic [PIX_W-1:0] in_pixel,
  input  wire fr90_qstat_t      q_stat,
  output logic                  push,
  output fr90_op_t              push_op
);

  logic [ADDR_W-1:0] load_index;
  logic [ADDR_W-1:0] load_index_next;
  logic [CNT_W-1:0]  out_row;
  logic [CNT_W-1:0]  out_row_next;
  logic [CNT_W-1:0]  out_col;
  logic [CNT_W-1:0]  out_col_next;

  logic [DIM_W-1:0]  wc;
  logic [DIM_W-1:0]  hc;
  logic [SIZE_W-1:0] size;
  logic              rot0;
  logic              half;
  logic [DIM_W-1:0]  nrows;
  logic [DIM_W-1:0]  rowlen;
  logic [CNT_W-1:0]  r;
  logic [CNT_W-1:0]  c;
  logic [SIZE_W-1:0] mul;
  logic [SIZE_W-1:0] src;
  logic [SIZE_W-1:0] li;
  logic [SIZE_W-1:0] li_inc;
  logic              last_col;
  logic              last_row;
  logic              accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  always_comb begin
    wc     = clamp_dim(cfg.width);
    hc     = clamp_dim(cfg.height);
    size   = SIZE_W'(wc) * SIZE_W'(hc);
    rot0   = (cfg.rotation == ROT_QUARTER);
    half   = (cfg.rotation == ROT_HALF);
    nrows  = rot0 ? wc : hc;
    rowlen = rot0 ? hc : wc;

    // restart counters left beyond the frame by a size change
    r = (DIM_W'(out_row) >= nrows) ? '0 : out_row;
    c = (DIM_W'(out_col) >= rowlen) ? '0 : out_col;

    mul = SIZE_W'(rot0 ? c : r) * SIZE_W'(wc);
    if (rot0) begin
      src = mul + SIZE_W'(wc) - SIZE_W'(1) - SIZE_W'(r);
    end else if (half) begin
      src = size - SIZE_W'(1) - (mul + SIZE_W'(c));
    end else begin
      src = mul + SIZE_W'(c);
    end

    last_col = ((DIM_W'(c) + DIM_W'(1)) == rowlen);
    last_row = ((DIM_W'(r) + DIM_W'(1)) == nrows);

    li     = (SIZE_W'(load_index) >= size) ? '0 : SIZE_W'(load_index);
    li_inc = li + SIZE_W'(1);

    load_index_next = load_index;
    out_row_next    = out_row;
    out_col_next    = out_col;
    if (accept && in_mode == MODE_LOAD) begin
      load_index_next = (li_inc >= size) ? '0 : li_inc[ADDR_W-1:0];
    end
    if (accept && in_mode == MODE_FETCH) begin
      if (last_col) begin
        out_col_next = '0;
        out_row_next = last_row ? '0 : r + CNT_W'(1);
      end else begin
        out_row_next = r;
        out_col_next = c + CNT_W'(1);
      end
    end

    push_op.fetch     = (in_mode == MODE_FETCH);
    push_op.addr      = (in_mode == MODE_FETCH) ? src[ADDR_W-1:0] : li[ADDR_W-1:0];
    push_op.pixel     = in_pixel;
    push_op.row_end   = last_col;
    push_op.frame_end = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
      out_row    <= '0;
      out_col    <= '0;
    end else begin
      load_index <= load_index_next;
      out_row    <= out_row_next;
      out_col    <= out_col_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fr90_back.sv
// ---------------------------------------------------------------------------
// fr90_back
// Executes queued operations on the frame store and buffers fetched pixels.
// ---------------------------------------------------------------------------
`default_nettype none
`include "frame_rotator_90_180_macros.svh"

module fr90_back
  import fr90_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire fr90_op_t    head,
  input  wire fr90_qstat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output fr90_pix_t        out_pix
);

  logic [PIX_W-1:0] rdata;
  logic             rd_pend;
  logic             rd_row_end;
  logic             rd_frame_end;
  logic [1:0]       n_out;
  logic [1:0]       n_out_next;
  logic [1:0]       n_mid;
  logic [1:0]       occ_after;
  fr90_pix_t        slot0;
  fr90_pix_t        slot0_next;
  fr90_pix_t        slot1;
  fr90_pix_t        slot1_next;
  fr90_pix_t        arriving;
  logic             fire;
  logic             can_fetch;

  fr90_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (pop),
    .we    (pop && !head.fetch),
    .addr  (head.addr),
    .wdata (head.pixel),
    .rdata (rdata)
  );

  assign out_valid = (n_out != 2'd0);
  assign out_pix   = slot0;
  assign fire      = out_valid && out_ready;

  always_comb begin
    // a fetch needs a buffer slot once the pending read has landed
    occ_after = n_out + {1'b0, rd_pend} - {1'b0, fire};
    can_fetch = (occ_after < 2'd2);
    pop       = !q_stat.empty && (!head.fetch || can_fetch);

    arriving.pixel     = rdata;
    arriving.row_end   = rd_row_end;
    arriving.frame_end = rd_frame_end;

    n_mid      = n_out - {1'b0, fire};
    slot0_next = fire ? slot1 : slot0;
    slot1_next = slot1;
    if (rd_pend) begin
      if (n_mid == 2'd0) begin
        slot0_next = arriving;
      end else begin
        slot1_next = arriving;
      end
    end
    n_out_next = n_mid + {1'b0, rd_pend};
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
    if (pop) begin
      rd_row_end   <= head.row_end;
      rd_frame_end <= head.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      n_out   <= 2'd0;
    end else begin
      rd_pend <= pop && head.fetch;
      n_out   <= n_out_next;
    end
  end

  `FR90_ASSERT(a_buf_room, clk, rst, (n_out + {1'b0, rd_pend}) <= 2'd2, "output buffer overrun")
  `FR90_ASSERT(a_drain_fire, clk, rst, $fell(out_valid) |-> $past(fire), "pixel dropped")

endmodule

`default_nettype wire
